/* src/oaid_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array package
// Shared widths, command and status codes, and the request, result and job
// records used by the ordered array insert/delete block.
// ----------------------------------------------------------------------------
package oaid_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CapacityMax  = 64;

  // Field widths of the request and result channels.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ElemW   = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CountW  = 5;

  // Index and count width that covers every supported capacity.
  localparam int unsigned PtrW = $clog2(CapacityMax + 1);

  // Depth of the job queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_PUSH     = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_UPDATE   = 3'd3,
    CMD_SEARCH   = 3'd4,
    CMD_TRAVERSE = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    JOB_REPORT,
    JOB_INSERT,
    JOB_DELETE,
    JOB_UPDATE,
    JOB_SEARCH,
    JOB_TRAVERSE
  } job_op_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ElemW-1:0] element;
    logic [PosW-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    found_index;
    logic [ElemW-1:0]   entry_value;
    logic [CountW-1:0]  entry_count;
    logic               last;
  } rsp_t;

  // A classified command on its way from the front part to the back part.
  typedef struct packed {
    job_op_e          op;
    status_e          status;
    logic [ElemW-1:0] word;
    logic [PtrW-1:0]  pos;
    logic [PtrW-1:0]  count;
  } job_t;

endpackage

/* src/oaid_if.sv */
// ----------------------------------------------------------------------------
// Ordered array channel interfaces
// Valid/ready channels for requests into and results out of the block.
// ----------------------------------------------------------------------------
interface oaid_req_if import oaid_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface oaid_rsp_if import oaid_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/oaid_front.sv */
// ----------------------------------------------------------------------------
// Ordered array front end
// Accepts requests, keeps the entry count and turns each request with a known
// command into a job with its status already settled.
// ----------------------------------------------------------------------------
module oaid_front import oaid_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oaid_req_if.sink    req_i,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_ready_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0] pos_x, cnt_x, ins_pos;
  logic            full;
  logic            has_job;
  logic            accept;

  assign pos_x  = CmpW'(req_i.data.position);
  assign cnt_x  = CmpW'(cnt_q);
  assign full   = (cnt_q == CntW'(CAPACITY));

  assign req_i.ready = job_ready_i;
  assign accept      = req_i.valid && req_i.ready;
  assign job_valid_o = req_i.valid && has_job;

  always_comb begin
    cnt_d        = cnt_q;
    has_job      = 1'b1;
    ins_pos      = pos_x;
    job_o.op     = JOB_REPORT;
    job_o.status = ST_OK;
    job_o.word   = req_i.data.element;
    job_o.pos    = PtrW'(req_i.data.position);
    unique case (req_i.data.command) inside
      CMD_INSERT, CMD_PUSH: begin
        if (req_i.data.command == CMD_PUSH) begin
          ins_pos = cnt_x;
        end
        if (ins_pos > cnt_x) begin
          job_o.status = ST_RANGE;
        end else if (full) begin
          job_o.status = ST_FULL;
        end else begin
          job_o.op  = JOB_INSERT;
          job_o.pos = PtrW'(ins_pos);
          cnt_d     = cnt_q + CntW'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_x >= cnt_x) begin
          job_o.status = ST_RANGE;
        end else begin
          job_o.op = JOB_DELETE;
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      CMD_UPDATE: begin
        if (pos_x >= cnt_x) begin
          job_o.status = ST_RANGE;
        end else begin
          job_o.op = JOB_UPDATE;
        end
      end
      CMD_SEARCH: begin
        job_o.op = JOB_SEARCH;
      end
      CMD_TRAVERSE: begin
        if (cnt_q == '0) begin
          job_o.status = ST_EMPTY;
        end else begin
          job_o.op = JOB_TRAVERSE;
        end
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
    job_o.count = PtrW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // The count tracked here must never pass the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

endmodule

/* src/oaid_queue.sv */
// ----------------------------------------------------------------------------
// Ordered array job queue
// Short first-in first-out buffer of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module oaid_queue import oaid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int unsigned Depth = QueueDepth;
  localparam int unsigned QPtrW = $clog2(Depth);
  localparam int unsigned QCntW = $clog2(Depth + 1);

  job_t             slot_q [Depth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + QPtrW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

endmodule

/* src/oaid_back.sv */
// ----------------------------------------------------------------------------
// Ordered array back end
// Holds the entry memory and carries out jobs: shifts for insert and delete,
// single writes for update, and scans for search and traverse.
// ----------------------------------------------------------------------------
module oaid_back import oaid_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  oaid_rsp_if.source  rsp_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_SCAN,
    S_FIN
  } state_e;

  state_e                state_q, state_d;
  job_op_e               op_q, op_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [AddrW-1:0]      pos_q, pos_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [AddrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                  pend_q, pend_d;
  logic                  hold_q, hold_d;
  status_e               res_status_q, res_status_d;
  logic [IdxW-1:0]       res_idx_q, res_idx_d;
  logic [ElemW-1:0]      res_val_q, res_val_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd;

  logic                  out_free;
  logic                  match;
  logic [CntW-1:0]       chk_idx;

  assign job_ready_o = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign chk_idx     = rd_ptr_q - CntW'(1);
  assign match       = (op_q == JOB_TRAVERSE) || (rd_q == word_q);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    word_d       = word_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    pend_d       = pend_q;
    hold_d       = hold_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_val_d    = res_val_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_wa       = wr_ptr_q;
    mem_wd       = word_q;
    mem_re       = 1'b0;
    mem_ra       = wr_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          op_d         = job_i.op;
          word_d       = DATA_WIDTH'(job_i.word);
          pos_d        = AddrW'(job_i.pos);
          cnt_d        = CntW'(job_i.count);
          res_status_d = job_i.status;
          res_idx_d    = '0;
          res_val_d    = '0;
          hold_d       = 1'b0;
          pend_d       = 1'b0;
          rd_ptr_d     = '0;
          unique case (job_i.op)
            JOB_INSERT: begin
              wr_ptr_d = AddrW'(job_i.count - PtrW'(1));
              state_d  = S_INS;
            end
            JOB_DELETE: begin
              wr_ptr_d = AddrW'(job_i.pos);
              state_d  = S_DEL;
            end
            JOB_UPDATE: begin
              mem_we  = 1'b1;
              mem_wa  = AddrW'(job_i.pos);
              mem_wd  = DATA_WIDTH'(job_i.word);
              state_d = S_FIN;
            end
            JOB_SEARCH: begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_SCAN;
            end
            JOB_TRAVERSE: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      // Walk down from the old last entry; the read of the next source
      // overlaps the write of the current destination.
      S_INS: begin
        if (wr_ptr_q == pos_q) begin
          mem_we  = 1'b1;
          mem_wa  = pos_q;
          mem_wd  = word_q;
          state_d = S_FIN;
        end else if (!pend_q) begin
          mem_re = 1'b1;
          mem_ra = wr_ptr_q - AddrW'(1);
          pend_d = 1'b1;
        end else begin
          mem_we   = 1'b1;
          mem_wa   = wr_ptr_q;
          mem_wd   = rd_q;
          wr_ptr_d = wr_ptr_q - AddrW'(1);
          if ((wr_ptr_q - AddrW'(1)) != pos_q) begin
            mem_re = 1'b1;
            mem_ra = wr_ptr_q - AddrW'(2);
            pend_d = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end
      end

      // Walk up from the deleted index to the new count.
      S_DEL: begin
        if (CntW'(wr_ptr_q) == cnt_q) begin
          state_d = S_FIN;
        end else if (!pend_q) begin
          mem_re = 1'b1;
          mem_ra = wr_ptr_q + AddrW'(1);
          pend_d = 1'b1;
        end else begin
          mem_we   = 1'b1;
          mem_wa   = wr_ptr_q;
          mem_wd   = rd_q;
          wr_ptr_d = wr_ptr_q + AddrW'(1);
          if ((CntW'(wr_ptr_q) + CntW'(1)) < cnt_q) begin
            mem_re = 1'b1;
            mem_ra = wr_ptr_q + AddrW'(2);
            pend_d = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end
      end

      // The newest hit is held back so that the final one can carry last.
      S_SCAN: begin
        if (pend_q && match && hold_q && !out_free) begin
          state_d = S_SCAN;
        end else begin
          if (pend_q) begin
            pend_d = 1'b0;
            if (match) begin
              if (hold_q) begin
                out_valid_d       = 1'b1;
                out_d.status      = res_status_q;
                out_d.found_index = res_idx_q;
                out_d.entry_value = res_val_q;
                out_d.entry_count = CountW'(cnt_q);
                out_d.last        = 1'b0;
              end
              res_status_d = ST_OK;
              res_idx_d    = IdxW'(chk_idx);
              res_val_d    = ElemW'(rd_q);
              hold_d       = 1'b1;
            end
          end
          if (rd_ptr_q != cnt_q) begin
            mem_re   = 1'b1;
            mem_ra   = AddrW'(rd_ptr_q);
            rd_ptr_d = rd_ptr_q + CntW'(1);
            pend_d   = 1'b1;
          end else if (!pend_q) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = res_status_q;
          out_d.found_index = res_idx_q;
          out_d.entry_value = res_val_q;
          out_d.entry_count = CountW'(cnt_q);
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= JOB_REPORT;
      word_q       <= '0;
      pos_q        <= '0;
      cnt_q        <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      pend_q       <= 1'b0;
      hold_q       <= 1'b0;
      res_status_q <= ST_OK;
      res_idx_q    <= '0;
      res_val_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      word_q       <= word_d;
      pos_q        <= pos_d;
      cnt_q        <= cnt_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      pend_q       <= pend_d;
      hold_q       <= hold_d;
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_val_q    <= res_val_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  // An insert shift never walks below the insert index.
  a_ins_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (wr_ptr_q >= pos_q))
    else $error("insert shift passed the insert index");

  // A delete shift never walks beyond the new count.
  a_del_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL) |-> (CntW'(wr_ptr_q) <= cnt_q))
    else $error("delete shift passed the entry count");

  // A pending scan read always belongs to an entry already addressed.
  a_scan_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (rd_ptr_q != '0))
    else $error("scan data pending without a read");

endmodule

/* src/ordered_array_insert_delete.sv */
// ----------------------------------------------------------------------------
// Ordered array with insert and delete at index
// Keeps an ordered list of up to CAPACITY words with insert, push, delete,
// update, search and traverse commands.
// ----------------------------------------------------------------------------
//
//   Port    Direction  Moves                        Handshake
//   req_i   in         command, element, position   valid/ready
//   rsp_o   out        status, found_index,         valid/ready
//                      entry_value, entry_count,
//                      last
//
// A request is taken when the job queue has room. With n entries in use, the
// back end shifts the entries from index p up to n - 1 for an insert at index
// p, shifts the entries above index p down for a delete, scans all n entries
// for a search or traverse and writes a single entry for an update. The entry
// memory takes one read and one write per cycle, so a shift overlaps the read
// of one entry with the write of another. Reset clears the count, the queue
// and the sequencer; the entry memory is not cleared and needs no clearing
// pass. A stalled result channel holds the back end, and a full queue then
// holds req_i.
//
// The front end settles the status of every job against its own entry
// count, so all range, full and empty checks finish at acceptance. Search and
// traverse hits leave the back end one result behind the scan, so that the
// final hit can be marked last. Codes 6 and 7 are taken and dropped.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete import oaid_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oaid_req_if.sink    req_i,
  oaid_rsp_if.source  rsp_o
);

  // Front end to queue.
  logic fq_valid;
  logic fq_ready;
  job_t fq_job;

  // Queue to back end.
  logic qb_valid;
  logic qb_ready;
  job_t qb_job;

  // Classification and entry count tracking.
  oaid_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_valid_o (fq_valid),
    .job_o       (fq_job),
    .job_ready_i (fq_ready)
  );

  // Decouples acceptance from the shifting and scanning in the back end.
  oaid_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  // Entry memory, shift and scan sequencer, and the result register.
  oaid_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .rsp_o       (rsp_o)
  );

endmodule
